/* rtl/ous_pkg.sv */
// Shared definitions for the ordered unique-set store: field widths, default
// sizes, command and status codes. Used by the interfaces and all modules.
package ous_pkg;

  localparam int OUS_CAPACITY      = 16;
  localparam int OUS_ELEMENT_WIDTH = 32;

  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [DATA_W-1:0] READ_MISS = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_READ     = 3'd3,
    CMD_CONTAINS = 3'd4,
    CMD_SCALE    = 3'd5,
    CMD_SUM      = 3'd6
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic shift;
    logic reverse;
  } ous_shift_t;

endpackage

/* rtl/ous_cmd_if.sv */
// Request channel of the ordered unique-set store.
// Depends on ous_pkg for the field widths.
interface ous_cmd_if import ous_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] element;
  logic [POS_W-1:0]         position;

  modport source (output valid, command, element, position, input ready);
  modport sink   (input valid, command, element, position, output ready);
endinterface

/* rtl/ous_res_if.sv */
// Result channel of the ordered unique-set store.
// Depends on ous_pkg for the field widths.
interface ous_res_if import ous_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     found;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, result_value, found, status, count, input ready);
  modport sink   (input valid, result_value, found, status, count, output ready);
endinterface

/* rtl/ordered_unique_set_store.sv */
// Ordered unique-set store: an ordered list of up to CAPACITY distinct elements
// held in a ring of cells that rotates one position per cycle while a request is
// being worked, past a head cell where all comparing, multiplying, summing and
// insertion happens; remove turns the ring the other way past the tail cell.
// Append and insert make one rotation for the duplicate check and one to place
// the element; remove, read, contains, scale and sum make one rotation; a remove
// or read out of range and an unused code finish without any rotation, and a
// rejected insert finishes after its check. A finished result waits in an output
// register, so the next request is taken while it is pending. Depends on ous_pkg,
// the two channel interfaces and ous_chain.
module ordered_unique_set_store import ous_pkg::*; #(
  parameter int CAPACITY      = OUS_CAPACITY,
  parameter int ELEMENT_WIDTH = OUS_ELEMENT_WIDTH
) (
  input logic      clk,
  input logic      rst,
  ous_cmd_if.sink  cmd,
  ous_res_if.source res
);

  localparam int KW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FWD, S_REV, S_DONE} state_t;

  state_t                   state;
  command_t                 op;
  status_t                  st;
  logic [KW-1:0]            k;
  logic [CW-1:0]            count;
  logic [CW-1:0]            p;
  logic [POS_W-1:0]         pos;
  logic [ELEMENT_WIDTH-1:0] elem;
  logic [ELEMENT_WIDTH-1:0] carry;
  logic [ELEMENT_WIDTH-1:0] acc;
  logic                     hit;

  logic                     out_valid;
  logic [DATA_W-1:0]        out_value;
  logic                     out_found;
  logic [STATUS_W-1:0]      out_status;
  logic [COUNT_W-1:0]       out_count;

  ous_shift_t               ctrl;
  logic [ELEMENT_WIDTH-1:0] feed;
  logic [ELEMENT_WIDTH-1:0] head_fwd;
  logic [ELEMENT_WIDTH-1:0] head_rev;
  logic [ELEMENT_WIDTH-1:0] prod;
  logic [ELEMENT_WIDTH-1:0] elem_in;
  logic [KW-1:0]            rev_idx;
  logic [CW-1:0]            k_ext;
  logic [PW-1:0]            count_w;
  logic [PW-1:0]            pos_w;
  logic                     last_step;
  logic                     is_insert;
  logic                     in_range_in;
  logic                     hit_now;

  ous_chain #(.CAPACITY(CAPACITY), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .feed     (feed),
    .head_fwd (head_fwd),
    .head_rev (head_rev)
  );

  assign elem_in     = ELEMENT_WIDTH'(cmd.element);
  assign prod        = head_fwd * elem;
  assign last_step   = (k == KW'(CAPACITY - 1));
  assign rev_idx     = KW'(CAPACITY - 1) - k;
  assign k_ext       = CW'(k);
  assign count_w     = PW'(count);
  assign pos_w       = PW'(pos);
  assign is_insert   = (op == CMD_APPEND) || (op == CMD_INSERT);
  assign in_range_in = PW'(cmd.position) < count_w;
  assign hit_now     = hit || ((k_ext < count) && (head_fwd == elem));

  always_comb begin
    ctrl.shift   = 1'b0;
    ctrl.reverse = 1'b0;
    feed         = head_fwd;
    unique case (state)
      S_SCAN: begin
        ctrl.shift = 1'b1;
      end
      S_FWD: begin
        ctrl.shift = 1'b1;
        if (op == CMD_SCALE) begin
          feed = prod;
        end else if (is_insert) begin
          if (k_ext < p) begin
            feed = head_fwd;
          end else if (k_ext == p) begin
            feed = elem;
          end else begin
            feed = carry;
          end
        end
      end
      S_REV: begin
        ctrl.shift   = 1'b1;
        ctrl.reverse = 1'b1;
        feed         = (CW'(rev_idx) < p) ? head_rev : carry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op   <= command_t'(cmd.command);
            elem <= elem_in;
            pos  <= cmd.position;
            k    <= '0;
            acc  <= '0;
            unique case (command_t'(cmd.command))
              CMD_APPEND, CMD_INSERT, CMD_CONTAINS: begin
                hit   <= 1'b0;
                st    <= ST_OK;
                state <= S_SCAN;
              end
              CMD_REMOVE: begin
                hit <= 1'b0;
                if (in_range_in) begin
                  st    <= ST_OK;
                  p     <= CW'(cmd.position);
                  state <= S_REV;
                end else begin
                  st    <= ST_RANGE;
                  state <= S_DONE;
                end
              end
              CMD_READ: begin
                if (in_range_in) begin
                  hit   <= 1'b1;
                  st    <= ST_OK;
                  state <= S_FWD;
                end else begin
                  hit   <= 1'b0;
                  st    <= ST_RANGE;
                  state <= S_DONE;
                end
              end
              CMD_SCALE, CMD_SUM: begin
                hit   <= 1'b0;
                st    <= ST_OK;
                state <= S_FWD;
              end
              default: begin
                hit   <= 1'b0;
                st    <= ST_OK;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          k   <= last_step ? '0 : k + KW'(1);
          hit <= hit_now;
          if (last_step) begin
            if (op == CMD_CONTAINS) begin
              state <= S_DONE;
            end else if (hit_now) begin
              st    <= ST_DUP;
              state <= S_DONE;
            end else if (count >= CW'(CAPACITY)) begin
              st    <= ST_FULL;
              state <= S_DONE;
            end else begin
              p     <= (op == CMD_APPEND || pos_w >= count_w) ? count : CW'(pos);
              state <= S_FWD;
            end
          end
        end
        S_FWD: begin
          k     <= last_step ? '0 : k + KW'(1);
          carry <= head_fwd;
          if (op == CMD_SUM && k_ext < count) begin
            acc <= acc + head_fwd;
          end
          if (op == CMD_READ && PW'(k) == pos_w) begin
            acc <= head_fwd;
          end
          if (last_step) begin
            if (is_insert) begin
              count <= count + CW'(1);
            end
            state <= S_DONE;
          end
        end
        S_REV: begin
          k     <= last_step ? '0 : k + KW'(1);
          carry <= head_rev;
          if (last_step) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid  <= 1'b1;
            out_value  <= (op == CMD_READ && st == ST_RANGE) ? READ_MISS
                                                             : DATA_W'(signed'(acc));
            out_found  <= hit && (op == CMD_CONTAINS || op == CMD_READ);
            out_status <= st;
            out_count  <= COUNT_W'(count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.ready        = (state == S_IDLE);
  assign res.valid        = out_valid;
  assign res.result_value = out_value;
  assign res.found        = out_found;
  assign res.status       = out_status;
  assign res.count        = out_count;

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_FWD && is_insert && last_step) |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count by one");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_REV && last_step) |=> count == $past(count) - CW'(1))
    else $error("remove did not shrink the count by one");

  a_insert_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_FWD && is_insert) |-> count < CW'(CAPACITY))
    else $error("insert placed into a full store");

  a_scan_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> $stable(count))
    else $error("count changed during the membership scan");

endmodule

/* rtl/ous_cell.sv */
// One storage cell of the element ring: holds one entry and loads from its
// left or right neighbor on a shift. Depends on ous_pkg for the control struct.
module ous_cell import ous_pkg::*; #(
  parameter int ELEMENT_WIDTH = OUS_ELEMENT_WIDTH
) (
  input  logic                     clk,
  input  ous_shift_t               ctrl,
  input  logic [ELEMENT_WIDTH-1:0] from_left,
  input  logic [ELEMENT_WIDTH-1:0] from_right,
  output logic [ELEMENT_WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      q <= ctrl.reverse ? from_left : from_right;
    end
  end

endmodule

/* rtl/ous_chain.sv */
// Row of ous_cell instances closed into a ring through the feed input.
// Depends on ous_pkg and ous_cell.
module ous_chain import ous_pkg::*; #(
  parameter int CAPACITY      = OUS_CAPACITY,
  parameter int ELEMENT_WIDTH = OUS_ELEMENT_WIDTH
) (
  input  logic                     clk,
  input  ous_shift_t               ctrl,
  input  logic [ELEMENT_WIDTH-1:0] feed,
  output logic [ELEMENT_WIDTH-1:0] head_fwd,
  output logic [ELEMENT_WIDTH-1:0] head_rev
);

  logic [ELEMENT_WIDTH-1:0] q [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_in;
    logic [ELEMENT_WIDTH-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = feed;
    end else begin : g_mid_l
      assign left_in = q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = feed;
    end else begin : g_mid_r
      assign right_in = q[i+1];
    end

    ous_cell #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_left  (left_in),
      .from_right (right_in),
      .q          (q[i])
    );
  end

  assign head_fwd = q[0];
  assign head_rev = q[CAPACITY-1];

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Testbench for ordered_unique_set_store: directed and random requests with idling on both
// channels, a predictor of the ordered set, and a field-by-field check of every result.
// Depends on ous_pkg, ous_cmd_if, ous_res_if and the ordered_unique_set_store RTL.
module tb;
  import ous_pkg::*;

  localparam int CAP = OUS_CAPACITY;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_REQUESTS = 550;
  localparam int HOLD_AT = 120;
  localparam int HOLD_LEN = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] element;
    logic [POS_W-1:0]         position;
  } request_t;

  typedef struct packed {
    request_t req;
    logic     drain;
  } queued_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     found;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
  } result_t;

  typedef struct packed {
    logic [CAP-1:0][DATA_W-1:0] cells;
    logic [COUNT_W-1:0]         n;
  } store_t;

  logic clk;
  logic rst;

  ous_cmd_if cmd_ch ();
  ous_res_if res_ch ();

  ordered_unique_set_store dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  queued_t queued_requests[$];
  result_t awaited_results[$];
  store_t  held;
  store_t  planned;
  int      errors;
  int      sent;
  int      checked;
  int      sender_gap;
  int      stall_left;
  int      hold_left;
  int      cycles;

  function automatic result_t apply_request(inout store_t s, input request_t r);
    result_t o;
    logic hit;
    logic [DATA_W-1:0] acc;
    int at;
    o = '0;
    o.status = ST_OK;
    hit = 1'b0;
    acc = '0;
    for (int k = 0; k < s.n; k++) begin
      if (s.cells[k] == r.element) hit = 1'b1;
    end
    case (r.command)
      CMD_APPEND, CMD_INSERT: begin
        at = (r.command == CMD_APPEND || r.position > s.n) ? int'(s.n) : int'(r.position);
        if (hit) begin
          o.status = ST_DUP;
        end else if (s.n >= CAP) begin
          o.status = ST_FULL;
        end else begin
          for (int k = s.n; k > at; k--) s.cells[k] = s.cells[k-1];
          s.cells[at] = r.element;
          s.n = s.n + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (r.position >= s.n) begin
          o.status = ST_RANGE;
        end else begin
          for (int k = r.position; k + 1 < s.n; k++) s.cells[k] = s.cells[k+1];
          s.n = s.n - 1'b1;
        end
      end
      CMD_READ: begin
        if (r.position >= s.n) begin
          o.value = READ_MISS;
          o.status = ST_RANGE;
        end else begin
          o.value = s.cells[r.position];
          o.found = 1'b1;
        end
      end
      CMD_CONTAINS: o.found = hit;
      CMD_SCALE: begin
        for (int k = 0; k < s.n; k++) s.cells[k] = s.cells[k] * r.element;
      end
      CMD_SUM: begin
        for (int k = 0; k < s.n; k++) acc = acc + s.cells[k];
        o.value = acc;
      end
      default: ;
    endcase
    o.count = s.n;
    return o;
  endfunction

  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [DATA_W-1:0] pick_element(store_t s);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30 && s.n != 0) return s.cells[$urandom_range(0, s.n - 1)];
    if (roll < 50) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    if (roll < 70) return $urandom_range(0, 40) - 20;
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(logic grow);
    int roll;
    roll = $urandom_range(0, 99);
    if (grow) begin
      if (roll < 30) return CMD_APPEND;
      if (roll < 60) return CMD_INSERT;
      if (roll < 68) return CMD_REMOVE;
    end else begin
      if (roll < 10) return CMD_APPEND;
      if (roll < 20) return CMD_INSERT;
      if (roll < 60) return CMD_REMOVE;
    end
    if (roll < 75) return CMD_READ;
    if (roll < 86) return CMD_CONTAINS;
    if (roll < 91) return CMD_SCALE;
    if (roll < 97) return CMD_SUM;
    return CMD_UNUSED;
  endfunction

  task automatic add_request(logic [CMD_W-1:0] command, logic [DATA_W-1:0] element,
                             logic [POS_W-1:0] position, logic drain);
    queued_t q;
    result_t ignored;
    q.req.command = command;
    q.req.element = element;
    q.req.position = position;
    q.drain = drain;
    ignored = apply_request(planned, q.req);
    queued_requests.push_back(q);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = '0;
    cmd_ch.element = '0;
    cmd_ch.position = '0;
    res_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ordered_unique_set_store: mismatch");
      $finish;
    end
  end

  initial begin
    logic grow;
    logic [CMD_W-1:0] command;
    logic [DATA_W-1:0] element;
    logic [POS_W-1:0] position;
    planned = '0;
    held = '0;

    add_request(CMD_SUM, 32'h0, 5'd0, 1'b0);
    add_request(CMD_REMOVE, 32'h0, 5'd0, 1'b0);
    add_request(CMD_INSERT, 32'd5, 5'd31, 1'b0);
    add_request(CMD_READ, 32'h0, 5'd0, 1'b0);
    add_request(CMD_APPEND, 32'h7fff_ffff, 5'd0, 1'b0);
    add_request(CMD_APPEND, 32'h8000_0000, 5'd0, 1'b0);
    add_request(CMD_APPEND, 32'd5, 5'd0, 1'b0);
    add_request(CMD_INSERT, 32'hffff_ffff, 5'd1, 1'b0);
    add_request(CMD_INSERT, 32'h0, 5'd0, 1'b0);
    add_request(CMD_READ, 32'h0, 5'd31, 1'b0);
    add_request(CMD_READ, 32'h0, 5'd5, 1'b0);
    add_request(CMD_READ, 32'h0, 5'd4, 1'b0);
    add_request(CMD_CONTAINS, 32'h8000_0000, 5'd0, 1'b0);
    add_request(CMD_CONTAINS, 32'd12345, 5'd0, 1'b0);
    add_request(CMD_SCALE, 32'hffff_ffff, 5'd0, 1'b0);
    add_request(CMD_SUM, 32'h0, 5'd0, 1'b0);
    add_request(CMD_REMOVE, 32'h0, 5'd9, 1'b0);
    add_request(CMD_REMOVE, 32'h0, 5'd5, 1'b0);
    add_request(CMD_REMOVE, 32'h0, 5'd0, 1'b0);
    add_request(CMD_UNUSED, 32'hffff_ffff, 5'd31, 1'b0);
    add_request(CMD_SCALE, 32'd3, 5'd31, 1'b0);
    add_request(CMD_SUM, 32'h0, 5'd0, 1'b0);

    grow = 1'b1;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 40 == 0) grow = (i < 80) ? 1'b1 : 1'($urandom_range(0, 1));
      command = pick_command(grow);
      element = pick_element(planned);
      if (command == CMD_SCALE) begin
        case ($urandom_range(0, 9))
          0: element = 32'h0;
          1, 2: element = 32'hffff_ffff;
          3, 4: element = 32'h1;
          5, 6: element = $urandom_range(2, 5);
          default: element = $urandom;
        endcase
      end
      if ($urandom_range(0, 3) == 0) position = $urandom_range(0, 31);
      else position = $urandom_range(0, planned.n);
      add_request(command, element, position, i == RANDOM_REQUESTS / 2);
    end

    wait (!rst);
    wait (queued_requests.size() == 0 && awaited_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("ordered_unique_set_store: match");
    end else begin
      $display("ordered_unique_set_store: mismatch");
    end
    $finish;
  end

  always @(posedge clk) begin
    logic offer;
    queued_t issued;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      sender_gap = 0;
    end else begin
      offer = cmd_ch.valid;
      if (cmd_ch.valid && cmd_ch.ready) begin
        issued = queued_requests.pop_front();
        awaited_results.push_back(apply_request(held, issued.req));
        sent++;
        offer = 1'b0;
        sender_gap = ((sent / 50) % 4 == 3) ? 0 : idle_cycles();
      end
      if (!offer) begin
        if (sender_gap > 0) begin
          sender_gap--;
        end else if (queued_requests.size() != 0 &&
                     !(queued_requests[0].drain && awaited_results.size() != 0)) begin
          cmd_ch.command <= queued_requests[0].req.command;
          cmd_ch.element <= queued_requests[0].req.element;
          cmd_ch.position <= queued_requests[0].req.position;
          offer = 1'b1;
        end
      end
      cmd_ch.valid <= offer;
    end
  end

  always @(posedge clk) begin
    logic take;
    result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        checked++;
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (res_ch.result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, res_ch.result_value);
            errors++;
          end
          if (res_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, res_ch.found);
            errors++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_ch.status);
            errors++;
          end
          if (res_ch.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, res_ch.count);
            errors++;
          end
        end
        if (checked == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        take = 1'b1;
        if ((checked / 70) % 4 != 1 && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
      end
      res_ch.ready <= take;
    end
  end

endmodule

/* filelist.f */
rtl/ous_pkg.sv
rtl/ous_cmd_if.sv
rtl/ous_res_if.sv
rtl/ous_cell.sv
rtl/ous_chain.sv
rtl/ordered_unique_set_store.sv
bench/tb.sv
